@@ rtl/core/keyboard_scan_modifier_fifo_macros.svh @@
// Assertion helpers for the checker file of this block.
// Every macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef KEYBOARD_SCAN_MODIFIER_FIFO_MACROS_SVH
`define KEYBOARD_SCAN_MODIFIER_FIFO_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSMF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSMF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ksmf_pkg.sv @@
`default_nettype none

package ksmf_pkg;

	localparam int unsigned MOD_W = 12;
	localparam int unsigned LED_W = 3;
	localparam int unsigned QUEUED_W = 10;

	// Bit positions in the modifier word.
	localparam int unsigned MB_RSHIFT = 0;
	localparam int unsigned MB_LSHIFT = 1;
	localparam int unsigned MB_RCTRL  = 2;
	localparam int unsigned MB_LCTRL  = 3;
	localparam int unsigned MB_RALT   = 4;
	localparam int unsigned MB_LALT   = 5;
	localparam int unsigned MB_SCROLL = 6;
	localparam int unsigned MB_NUM    = 7;
	localparam int unsigned MB_CAPS   = 8;
	localparam int unsigned MB_INS    = 9;
	localparam int unsigned MB_SYSRQ  = 10;
	localparam int unsigned MB_HOLD   = 11;

	// Input action codes.
	localparam logic ACT_SCAN = 1'b0;
	localparam logic ACT_READ = 1'b1;

	// Set-1 scan bytes.
	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [7:0] SC_SYSRQ      = 8'h81;
	localparam logic [7:0] SC_RSHIFT_MK  = 8'h36;
	localparam logic [7:0] SC_RSHIFT_BRK = 8'hB6;
	localparam logic [7:0] SC_LSHIFT_MK  = 8'h2A;
	localparam logic [7:0] SC_LSHIFT_BRK = 8'hAA;
	localparam logic [7:0] SC_CTRL_MK    = 8'h1D;
	localparam logic [7:0] SC_CTRL_BRK   = 8'h9D;
	localparam logic [7:0] SC_ALT_MK     = 8'h38;
	localparam logic [7:0] SC_ALT_BRK    = 8'hB8;
	localparam logic [7:0] SC_SCROLL_MK  = 8'h46;
	localparam logic [7:0] SC_SCROLL_BRK = 8'hC6;
	localparam logic [7:0] SC_NUM_MK     = 8'h45;
	localparam logic [7:0] SC_NUM_BRK    = 8'hC5;
	localparam logic [7:0] SC_CAPS_BRK   = 8'hBA;
	localparam logic [7:0] SC_INS_MK     = 8'h52;
	localparam logic [7:0] SC_INS_BRK    = 8'hD2;

	typedef logic [MOD_W-1:0] mod_t;

endpackage

`default_nettype wire

@@ rtl/core/keyboard_scan_modifier_fifo.sv @@
`default_nettype none

// Set-1 scan byte modifier tracker with a key queue. Each input beat is either a scan byte
// (action 0) or a request to pop the oldest queued key (action 1), and each produces exactly
// one result beat. The block takes one beat per clock while in_stall is low; a result is
// registered in the first stage and then in the output register, where it stays presented
// until it is taken. The key queue is a synchronous memory whose read data is registered in
// the first stage, and the output register follows that stage. A first stage and an output
// register sit between the channels, so a new beat is still taken while a result waits;
// in_stall rises only when both are full and the output is stalled. The key memory is not
// cleared after reset: only entries that were written are ever popped.
module keyboard_scan_modifier_fifo #(
	parameter int unsigned FIFO_DEPTH = 512
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          action,
	input  wire logic [7:0]                    scan_code,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [7:0]                         key_code,
	output logic                               key_valid,
	output ksmf_pkg::mod_t                     modifier_status,
	output logic [ksmf_pkg::LED_W-1:0]         led_bits,
	output logic [ksmf_pkg::QUEUED_W-1:0]      keys_queued,
	output logic                               full_beep
);
	import ksmf_pkg::*;

	localparam int unsigned PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned SW = CW + 1;

	logic [7:0] key_store [FIFO_DEPTH];

	mod_t          flags_q, flags_nx;
	logic          prefix_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic          valid_s1;
	logic [7:0]    rd_s1;
	logic          key_valid_s1;
	logic          beep_s1;
	mod_t          flags_s1;
	logic [CW-1:0] count_s1;

	logic          out_valid_q;
	logic [7:0]    key_code_q;
	logic          key_valid_q;
	logic          beep_q;
	mod_t          flags_out_q;
	logic [CW-1:0] count_out_q;

	logic          in_accept;
	logic          s1_adv;
	logic          is_read;
	logic          do_pop;
	logic          is_make;
	logic          fifo_full;
	logic          do_push;
	logic          do_beep;
	logic [SW-1:0] slot_sum;
	logic [PW-1:0] wr_slot;
	logic [PW-1:0] rd_ptr_inc;
	logic [CW-1:0] count_nx;
	logic [CW+QUEUED_W-1:0] count_ext;

	// The first stage moves on whenever the output register is empty or being taken.
	assign s1_adv    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	assign is_read   = (action == ACT_READ);
	assign fifo_full = (count_q >= CW'(FIFO_DEPTH));
	assign is_make   = (scan_code < SC_SYSRQ);
	assign do_pop    = is_read && (count_q != '0);
	assign do_push   = !is_read && is_make && !fifo_full;
	assign do_beep   = !is_read && is_make && fifo_full;

	assign slot_sum   = SW'(rd_ptr_q) + SW'(count_q);
	assign wr_slot    = (slot_sum >= SW'(FIFO_DEPTH)) ? PW'(slot_sum - SW'(FIFO_DEPTH))
							: PW'(slot_sum);
	assign rd_ptr_inc = (rd_ptr_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;

	always_comb begin
		count_nx = count_q;
		if (do_pop) begin
			count_nx = count_q - 1'b1;
		end else if (do_push) begin
			count_nx = count_q + 1'b1;
		end
	end

	// A prefixed Ctrl, Alt or NumLock byte lands on the right-hand or Hold bit instead.
	always_comb begin
		flags_nx = flags_q;
		if (!is_read) begin
			case (scan_code)
				SC_RSHIFT_MK:  flags_nx[MB_RSHIFT] = 1'b1;
				SC_RSHIFT_BRK: flags_nx[MB_RSHIFT] = 1'b0;
				SC_LSHIFT_MK:  flags_nx[MB_LSHIFT] = 1'b1;
				SC_LSHIFT_BRK: flags_nx[MB_LSHIFT] = 1'b0;
				SC_CTRL_MK: begin
					if (prefix_q) flags_nx[MB_RCTRL] = 1'b1;
					else flags_nx[MB_LCTRL] = 1'b1;
				end
				SC_CTRL_BRK: begin
					if (prefix_q) flags_nx[MB_RCTRL] = 1'b0;
					else flags_nx[MB_LCTRL] = 1'b0;
				end
				SC_ALT_MK: begin
					if (prefix_q) flags_nx[MB_RALT] = 1'b1;
					else flags_nx[MB_LALT] = 1'b1;
				end
				SC_ALT_BRK: begin
					if (prefix_q) flags_nx[MB_RALT] = 1'b0;
					else flags_nx[MB_LALT] = 1'b0;
				end
				SC_SCROLL_MK:  flags_nx[MB_SCROLL] = 1'b1;
				SC_SCROLL_BRK: flags_nx[MB_SCROLL] = 1'b0;
				SC_NUM_MK: begin
					if (prefix_q) flags_nx[MB_HOLD] = 1'b1;
					else flags_nx[MB_NUM] = 1'b1;
				end
				SC_NUM_BRK: begin
					if (prefix_q) flags_nx[MB_HOLD] = 1'b0;
					else flags_nx[MB_NUM] = 1'b0;
				end
				SC_CAPS_BRK:   flags_nx[MB_CAPS] = ~flags_q[MB_CAPS];
				SC_INS_MK:     flags_nx[MB_INS] = 1'b1;
				SC_INS_BRK:    flags_nx[MB_INS] = 1'b0;
				SC_SYSRQ:      flags_nx[MB_SYSRQ] = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && do_push) begin
			key_store[wr_slot] <= scan_code;
		end
		if (in_accept && is_read) begin
			rd_s1 <= key_store[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= '0;
			prefix_q <= 1'b0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (in_accept) begin
			flags_q <= flags_nx;
			count_q <= count_nx;
			if (!is_read) begin
				prefix_q <= (scan_code == SC_PREFIX);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			key_valid_s1 <= do_pop;
			beep_s1      <= do_beep;
			flags_s1     <= flags_nx;
			count_s1     <= count_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			key_code_q  <= key_valid_s1 ? rd_s1 : 8'h00;
			key_valid_q <= key_valid_s1;
			beep_q      <= beep_s1;
			flags_out_q <= flags_s1;
			count_out_q <= count_s1;
		end
	end

	assign count_ext = {{QUEUED_W{1'b0}}, count_out_q};

	assign out_valid       = out_valid_q;
	assign key_code        = key_code_q;
	assign key_valid       = key_valid_q;
	assign full_beep       = beep_q;
	assign modifier_status = flags_out_q;
	assign led_bits        = {flags_out_q[MB_CAPS], flags_out_q[MB_NUM], flags_out_q[MB_SCROLL]};
	assign keys_queued     = count_ext[QUEUED_W-1:0];

endmodule

`default_nettype wire

@@ rtl/core/ksmf_checker.sv @@
`default_nettype none

`include "keyboard_scan_modifier_fifo_macros.svh"

module ksmf_checker #(
	parameter int unsigned FIFO_DEPTH = 512
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire logic                          action,
	input wire logic [7:0]                    scan_code,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire logic [7:0]                    key_code,
	input wire logic                          key_valid,
	input wire ksmf_pkg::mod_t                modifier_status,
	input wire logic [ksmf_pkg::LED_W-1:0]    led_bits,
	input wire logic [ksmf_pkg::QUEUED_W-1:0] keys_queued,
	input wire logic                          full_beep
);
	import ksmf_pkg::*;

	logic led_match;
	logic depth_ok;

	assign led_match = (led_bits == {modifier_status[MB_CAPS], modifier_status[MB_NUM],
		modifier_status[MB_SCROLL]});
	// The fill level is masked on the port, so it is only bounded when the depth fits.
	assign depth_ok = (FIFO_DEPTH > 1023) || (32'(keys_queued) <= FIFO_DEPTH);

	// The LED bits must always follow the lock bits of the same beat.
	`KSMF_ASSERT_NOW(a_led_follows_locks, out_valid, led_match, "led_bits disagree with locks")
	// A beat without a popped key carries a zero key code.
	`KSMF_ASSERT_NOW(a_empty_key_zero, out_valid && !key_valid, key_code == 8'h00,
		"key_code nonzero without key_valid")
	// A pop and a dropped make code cannot come from the same beat, and the fill level stays within the depth.
	`KSMF_ASSERT_NOW(a_pop_xor_beep, out_valid, !(key_valid && full_beep) && depth_ok,
		"key_valid with full_beep, or fill level over depth")
	// A stalled result beat stays presented.
	`KSMF_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid,
		"out_valid dropped while stalled")

endmodule

bind keyboard_scan_modifier_fifo ksmf_checker #(.FIFO_DEPTH(FIFO_DEPTH)) u_ksmf_checker (.*);

`default_nettype wire
